// File: design/gmi_pkg.sv
// Shared constants and types for the gradient magnitude core.
package gmi_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 8;

  localparam int PIX_W = 8;
  localparam int MAG_W = 12;
  localparam int RAD_CFG_W = 4;
  localparam int DIM_CFG_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC
  } seq_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ROOT,
    SQ_DIV
  } sq_state_t;
endpackage

// File: design/gradient_magnitude_image_core.sv
// Top level of the gradient magnitude core: control, line store, magnitude unit.
// Per pixel: transfer, two line store read phases, differences and write-back; a
// pixel with a result then runs through the square root and the divider, and the
// next pixel is taken only after that result is transferred. A pixel without a
// result frees the core after write-back. The iterative root and divider set the pace.
// Reset (synchronous, rst): radius 1, 640 x 480, row/column 0; line store not cleared.
module gradient_magnitude_image_core import gmi_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [MAG_W-1:0]      magnitude,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int ROWS  = 2 * MAX_RADIUS;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int RW    = $clog2(MAX_RADIUS) + 1;
  localparam int SW    = $clog2(ROWS);
  localparam int CW    = XW + 2;
  localparam int DEPTH = ROWS * (2 ** XW);
  localparam int AW    = $clog2(DEPTH);

  // raw config registers
  logic [RAD_CFG_W-1:0] radius;
  logic [DIM_CFG_W-1:0] frame_width, frame_height;
  // effective, clamped values
  logic [RW-1:0] r_eff;
  logic [CW-1:0] w_eff, h_eff;

  always_comb begin
    if (radius == '0) r_eff = RW'(1);
    else if (32'(radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius);
    if (frame_width == '0) w_eff = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    if (frame_height == '0) h_eff = CW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = CW'(MAX_HEIGHT);
    else h_eff = CW'(frame_height);
  end

  // position and store row slot of the current row
  seq_state_t      state, state_next;
  logic [XW-1:0]   col;
  logic [YW-1:0]   row;
  logic [SW-1:0]   slot_cur;       // row mod ROWS
  logic [PIX_W-1:0] pix_hold;
  logic            emit, last_hold;
  logic            out_full;

  logic [CW-1:0] x_ext, y_ext, r_ext;
  logic          has_res;
  logic [SW-1:0] slot_top, slot_ctr;
  logic [AW-1:0] ra, rb, wa;
  logic [PIX_W-1:0] rd_a, rd_b, rd_top;
  logic          mem_we;
  logic          mag_busy, mag_done, mag_start;
  logic [MAG_W-1:0] mag_val;
  logic signed [PIX_W:0] dy, dx;
  logic          cfg_fire, in_fire;

  assign x_ext = CW'(col);
  assign y_ext = CW'(row);
  assign r_ext = CW'(r_eff);
  assign has_res = (y_ext >= (r_ext << 1)) && (x_ext >= r_ext) && (x_ext + r_ext < w_eff);

  // slots: (row - 2r) mod ROWS and (row - r) mod ROWS, with ROWS = 2*MAX_RADIUS
  always_comb begin
    logic [SW:0] t;
    t = {1'b0, slot_cur} + (SW+1)'(ROWS) - (SW+1)'({r_eff, 1'b0});
    slot_top = (t >= (SW+1)'(ROWS)) ? SW'(t - (SW+1)'(ROWS)) : SW'(t);
    t = {1'b0, slot_cur} + (SW+1)'(ROWS) - (SW+1)'(r_eff);
    slot_ctr = (t >= (SW+1)'(ROWS)) ? SW'(t - (SW+1)'(ROWS)) : SW'(t);
  end

  // state READ issues ctr-row reads at x+r and x-r; the top pixel read follows in the second READ phase
  logic rd_phase;
  always_comb begin
    if (!rd_phase) begin
      ra = AW'({slot_ctr, XW'(x_ext + r_ext)});
      rb = AW'({slot_ctr, XW'(x_ext - r_ext)});
    end else begin
      ra = AW'({slot_top, col});
      rb = AW'({slot_top, col});
    end
    wa = AW'({slot_cur, col});
  end

  gmi_line_mem #(.DEPTH(DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(wa), .wdata(pix_hold),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rd_a), .rdata_b(rd_b)
  );

  assign rd_top = rd_a;

  gmi_mag_unit #(.MAX_RADIUS(MAX_RADIUS)) u_mag (
    .clk(clk), .rst(rst), .start(mag_start), .dy(dy), .dx(dx), .rad(r_eff),
    .busy(mag_busy), .done(mag_done), .mag(mag_val)
  );

  assign cfg_fire    = cfg_valid && cfg_ready;
  assign in_fire     = pixel_valid && pixel_ready;
  // configuration is taken only while nothing is in flight; a finishing magnitude
  // counts as in flight, and so does a result until it is taken from the output register
  assign cfg_ready   = (state == ST_IDLE) && !mag_busy && !mag_done && !out_full;
  assign pixel_ready = (state == ST_IDLE) && !mag_busy && !mag_done && !out_full &&
                       !cfg_valid;

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mag_start  = 1'b0;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_READ;
      ST_READ: begin
        if (!rd_phase) state_next = ST_READ;
        else state_next = ST_CALC;
      end
      ST_CALC: begin
        // rd_a holds top pixel; dx captured earlier
        mag_start  = emit;
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  logic [PIX_W-1:0] ctr_right, ctr_left;
  always_comb begin
    dy = $signed({1'b0, pix_hold}) - $signed({1'b0, rd_top});
    dx = $signed({1'b0, ctr_right}) - $signed({1'b0, ctr_left});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_phase <= 1'b0;
      col      <= '0;
      row      <= '0;
      slot_cur <= '0;
      radius       <= RAD_CFG_W'(1);
      frame_width  <= DIM_CFG_W'(640);
      frame_height <= DIM_CFG_W'(480);
      out_full <= 1'b0;
      emit     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        case (cfg_index)
          REG_RADIUS: radius <= RAD_CFG_W'(cfg_data);
          REG_WIDTH:  frame_width <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
          col      <= '0;
          row      <= '0;
          slot_cur <= '0;
        end
      end
      if (in_fire) begin
        pix_hold  <= pixel;
        emit      <= has_res;
        last_hold <= (y_ext + 1'b1 == h_eff) && (x_ext + r_ext + 1'b1 == w_eff);
        rd_phase  <= 1'b0;
      end
      if (state == ST_READ) begin
        rd_phase <= 1'b1;
        if (!rd_phase) ;
        else begin
          ctr_right <= rd_a;
          ctr_left  <= rd_b;
        end
      end
      if (state == ST_CALC) begin
        rd_phase <= 1'b0;
        if (x_ext + 1'b1 >= w_eff) begin
          col <= '0;
          if (y_ext + 1'b1 >= h_eff) begin
            row      <= '0;
            slot_cur <= '0;
          end else begin
            row      <= row + 1'b1;
            slot_cur <= (32'(slot_cur) == ROWS - 1) ? '0 : slot_cur + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
      if (mag_done) out_full <= 1'b1;
      else if (result_valid && result_ready) out_full <= 1'b0;
    end
    if (mag_done) begin
      magnitude  <= mag_val;
      frame_last <= last_hold;
    end
  end

  assign result_valid = out_full;

  // a result is held until taken
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(magnitude))
    else $error("result dropped while stalled");
  // no new pixel while the magnitude unit works
  assert property (@(posedge clk) disable iff (rst)
    mag_busy |-> !pixel_ready)
    else $error("pixel accepted during magnitude computation");
  // the magnitude unit never finishes while an older result is pending
  assert property (@(posedge clk) disable iff (rst)
    mag_done |-> !out_full)
    else $error("result overrun");
endmodule

// File: design/gmi_line_mem.sv
// Line store: one write port, two registered read ports.
module gmi_line_mem import gmi_pkg::*; #(
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [PIX_W-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [PIX_W-1:0]         rdata_a,
  output logic [PIX_W-1:0]         rdata_b
);
  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// File: design/gmi_mag_unit.sv
// Iterative magnitude: squares, bit-pair square root, restoring divide by 2r.
module gmi_mag_unit import gmi_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [PIX_W:0]       dy,
  input  logic signed [PIX_W:0]       dx,
  input  logic [$clog2(MAX_RADIUS):0] rad,
  output logic                        busy,
  output logic                        done,
  output logic [MAG_W-1:0]            mag
);
  localparam int SUM_W  = 2 * PIX_W + 1;
  localparam int ROOT_W = (SUM_W + 8 + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;          // 256 * sum, padded to an even width
  localparam int DIVW   = $clog2(MAX_RADIUS) + 2;
  localparam int SCNT_W = $clog2(ROOT_W + 1);

  sq_state_t         state;
  logic [RAD_W-1:0]  rem;
  logic [RAD_W-1:0]  val;
  logic [ROOT_W-1:0] root;
  logic [SCNT_W-1:0] cnt;
  logic [DIVW-1:0]   divisor;
  logic [ROOT_W-1:0] quo;
  logic [DIVW:0]     drem;
  logic [ROOT_W+1:0] trial;
  logic [RAD_W-1:0]  rem_sh;
  logic [DIVW:0]     drem_sh;
  logic [2*PIX_W+1:0] sqy, sqx;

  always_comb begin
    sqy = (2*PIX_W+2)'(dy * dy);
    sqx = (2*PIX_W+2)'(dx * dx);
    rem_sh  = {rem[RAD_W-3:0], val[RAD_W-1 -: 2]};
    trial   = {root, 2'b01};
    drem_sh = {drem[DIVW-1:0], quo[ROOT_W-1]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      case (state)
        SQ_IDLE: begin
          if (start) begin
            val     <= RAD_W'({SUM_W'(sqy) + SUM_W'(sqx), 8'd0});
            rem     <= '0;
            root    <= '0;
            cnt     <= SCNT_W'(ROOT_W);
            divisor <= DIVW'({rad, 1'b0});
            state   <= SQ_ROOT;
          end
        end
        SQ_ROOT: begin
          val <= {val[RAD_W-3:0], 2'b00};
          if ((RAD_W+2)'(rem_sh) >= (RAD_W+2)'(trial)) begin
            rem  <= RAD_W'((RAD_W+2)'(rem_sh) - (RAD_W+2)'(trial));
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == SCNT_W'(1)) begin
            state <= SQ_DIV;
          end
        end
        SQ_DIV: begin
          if (cnt == '0) begin
            quo  <= root;
            drem <= '0;
            cnt  <= SCNT_W'(ROOT_W + 1);
          end else if (cnt == SCNT_W'(1)) begin
            mag   <= MAG_W'(quo);
            done  <= 1'b1;
            state <= SQ_IDLE;
          end else begin
            if (drem_sh >= (DIVW+1)'(divisor)) begin
              drem <= drem_sh - (DIVW+1)'(divisor);
              quo  <= {quo[ROOT_W-2:0], 1'b1};
            end else begin
              drem <= drem_sh;
              quo  <= {quo[ROOT_W-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

  assign busy = (state != SQ_IDLE);
endmodule

// File: test/testbench.sv
// Testbench for gradient_magnitude_image_core: directed frames, random frames, self-checking.
//
// A predictor mirrors the core: its own line store, row/column position and
// register copies.  Every pixel transfer is pushed through it, and every
// gradient it foresees is queued.  A monitor pops the queue on each result
// transfer and compares magnitude and frame_last.  Configuration is written
// only when no result is outstanding and the core has had time to go quiet.
module testbench;
  import gmi_pkg::*;

  // Index 3 is not a register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles the core may still be busy on a pixel with no result.
  localparam int QUIET_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int STORE_ROWS   = 2 * MAX_RADIUS_DEF;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
  } grad_t;

  logic                  clk;
  logic                  rst;
  logic                  pixel_valid;
  logic                  pixel_ready;
  logic [PIX_W-1:0]      pixel;
  logic                  result_valid;
  logic                  result_ready;
  logic [MAG_W-1:0]      magnitude;
  logic                  frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gradient_magnitude_image_core i_dut (.*);

  // Predictor state
  logic [PIX_W-1:0] line_mem [STORE_ROWS*MAX_WIDTH_DEF];
  int unsigned      row_pos, col_pos;
  int unsigned      radius_reg, width_reg, height_reg;
  grad_t            pending_grads[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned idle_pct;   // sender gap chance, percent per pixel
  int unsigned stall_pct;  // receiver stall chance, percent per cycle
  int unsigned pixels_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned root_floor(int unsigned v);
    int unsigned res;
    int unsigned b;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned store_slot(int unsigned row, int unsigned col);
    return (row % STORE_ROWS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF);
  endfunction

  // Advance the predictor by one accepted pixel; queue the gradient if one is due.
  function automatic void predict_gradient(logic [PIX_W-1:0] p);
    int unsigned r, w, h, y, x, s;
    int          dy, dx;
    grad_t       g;
    r = clip(radius_reg, 1, MAX_RADIUS_DEF);
    w = clip(width_reg, 1, MAX_WIDTH_DEF);
    h = clip(height_reg, 1, MAX_HEIGHT_DEF);
    y = row_pos;
    x = col_pos;
    if (y >= 2*r && x >= r && x + r < w) begin
      dy = int'(p) - int'(line_mem[store_slot(y - 2*r, x)]);
      dx = int'(line_mem[store_slot(y - r, x + r)]) - int'(line_mem[store_slot(y - r, x - r)]);
      s = dy*dy + dx*dx;
      g.mag = MAG_W'(root_floor(256 * s) / (2*r));
      g.last = (y + 1 == h) && (x + r + 1 == w);
      pending_grads.push_back(g);
    end
    line_mem[store_slot(y, x)] = p;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    row_pos = y;
    col_pos = x;
  endfunction

  // Receiver: random stalls, with stall_pct as the stall chance.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    grad_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_grads.size() == 0) begin
        $error("unexpected result transfer: magnitude %0d frame_last %0b", magnitude, frame_last);
        error_count++;
      end else begin
        want = pending_grads.pop_front();
        if (magnitude !== want.mag) begin
          $error("magnitude: expected %0d, got %0d", want.mag, magnitude);
          error_count++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gradient_magnitude_image_core test failed");
      $finish;
    end
  end

  // One pixel transfer; an optional gap first, valid held until accepted.
  task automatic send_pixel(logic [PIX_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= v;
    do @(posedge clk); while (!pixel_ready);
    predict_gradient(v);
    pixels_sent++;
  endtask

  // Stop sending, drain all outstanding results, then let the core go quiet.
  task automatic wait_quiet();
    pixel_valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS: radius_reg = val & 4'hF;
      REG_WIDTH:  width_reg = val & 11'h7FF;
      REG_HEIGHT: height_reg = val & 11'h7FF;
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic set_frame(int unsigned r, int unsigned w, int unsigned h);
    wait_quiet();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) send_pixel(pick_pixel());
  endtask

  // 3x3 frames where the single center sees the largest gradients, both signs.
  task automatic test_extremes();
    set_frame(1, 3, 3);
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'h00);
    send_pixel(8'h00); send_pixel(8'h5A); send_pixel(8'hFF);
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'h00);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'hFF);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h00);
    send_pixel(8'h80); send_pixel(8'h00); send_pixel(8'hA5);
  endtask

  // Radius zero and above the maximum, sizes zero, too-small frame, unused index.
  task automatic test_special_cfg();
    set_frame(0, 4, 4);
    send_random(16);
    set_frame(15, 17, 17);
    send_random(17*17);
    set_frame(2, 4, 10);                // too small: no results at all
    send_random(20);
    set_frame(1, 0, 5);                 // width zero acts as one: never interior
    send_random(6);
    set_frame(1, 5, 0);                 // height zero acts as one
    send_random(10);
    set_frame(1, 5, 4);
    send_random(7);
    wait_quiet();
    write_reg(REG_UNUSED, 11'h7FF);     // ignored: frame position must survive
    send_random(13);
  endtask

  // Widest and tallest settings: sizes above the maximum saturate.
  task automatic test_max_size();
    set_frame(1, 2047, 3);
    send_random(40);
    set_frame(1, 3, 2047);
    send_random(60);
    set_frame(8, 1024, 1024);
    send_random(40);
  endtask

  // Well-formed frames with random content, plus cut-off, doubled and too-narrow frames as noise.
  task automatic test_random_frames(int unsigned ip, int unsigned sp, int unsigned budget);
    int unsigned r, w, h, n, stop_at;
    idle_pct = ip;
    stall_pct = sp;
    stop_at = pixels_sent + budget;
    while (pixels_sent < stop_at) begin
      r = ($urandom_range(19) == 0) ? 8 : $urandom_range(1, 3);
      w = $urandom_range(2*r + 1, 2*r + 6);
      h = $urandom_range(2*r + 1, 2*r + 5);
      if ($urandom_range(9) == 0) w = $urandom_range(1, 2*r);
      set_frame(r, w, h);
      case ($urandom_range(9))
        0:       n = $urandom_range(1, w*h - 1);
        1, 2:    n = 2*w*h;
        default: n = w*h;
      endcase
      send_random(n);
    end
  endtask

  initial begin
    rst = 1'b1;
    pixel_valid <= 1'b0;
    pixel <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RADIUS;
    cfg_data <= '0;
    pixels_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    radius_reg = 1;
    width_reg = 640;
    height_reg = 480;
    row_pos = 0;
    col_pos = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_special_cfg();
    test_max_size();
    test_random_frames(0, 0, 240);
    test_random_frames(66, 0, 240);
    test_random_frames(0, 66, 240);
    test_random_frames(23, 23, 240);

    wait_quiet();
    if (error_count == 0) begin
      $display("gradient_magnitude_image_core test passed");
    end else begin
      $display("gradient_magnitude_image_core test failed");
    end
    $finish;
  end
endmodule
